FILE: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int unsigned HDR_BYTES  = 16;
	localparam int unsigned ALIGN_MASK = 15;
	localparam int unsigned OFF_W      = 24;
	localparam int unsigned REQ_W      = 25;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_NOFIT   = 3'd2,
		ST_NULL    = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_SPLIT,
		S_INS,
		S_RNEXT,
		S_RNEVAL,
		S_RPREV,
		S_RPEVAL,
		S_DROP,
		S_DROPW,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch request
		logic idx_clr;   // index := 0
		logic idx_inc;   // index++
		logic idx_dec;   // index--
		logic rd;        // read entry at index
		logic alloc_take;   // mark hit, no split
		logic alloc_split;  // shrink hit, prepare insert at index+1
		logic ins_step;  // one move of the insert shift, or final write
		logic rel_mark;  // mark block free
		logic merge_next;  // fold index+1 into index (held entry)
		logic merge_prev;  // fold index into index-1
		logic drop_start;  // begin drop at drop index
		logic drop_step;   // one move of drop shift
		logic set_status;
		status_t status;
		logic set_addr;
		logic out_load;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic req_zero;
		logic off_null;
		logic idx_end;      // index >= count
		logic fit;          // read entry free and big enough
		logic split_ok;
		logic match;        // read entry payload offset == request
		logic rd_free;
		logic at_first;     // index <= 1
		logic ins_done;
		logic drop_done;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for the allocator: scan, split/insert, release and merge steps.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ffba_pkg::sts_t  sts,
	output ffba_pkg::ctl_t  ctl
);
	import ffba_pkg::*;

	state_t state_q, state_d;
	logic   merged_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			merged_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE)
				merged_q <= 1'b0;
			else if (ctl.merge_next)
				merged_q <= 1'b1;
			else if (ctl.merge_prev)
				merged_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_SCAN;
			S_SCAN: begin
				priority if (sts.cmd == CMD_ALLOC && sts.req_zero) state_d = S_DONE;
				else if (sts.cmd == CMD_RELEASE && sts.off_null) state_d = S_DONE;
				else if (sts.idx_end) state_d = S_DONE;
				else state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.cmd == CMD_ALLOC) begin
					if (sts.fit) state_d = sts.split_ok ? S_SPLIT : S_DONE;
					else state_d = S_SCAN;
				end else begin
					if (sts.match) state_d = sts.rd_free ? S_DONE : S_RNEXT;
					else state_d = S_SCAN;
				end
			end
			S_SPLIT:  state_d = S_INS;
			S_INS:    if (sts.ins_done) state_d = S_DONE;
			S_RNEXT:  state_d = S_RNEVAL;
			S_RNEVAL: state_d = (!sts.idx_end && sts.rd_free) ? S_DROP : S_RPREV;
			S_RPREV:  state_d = sts.at_first ? S_DONE : S_RPEVAL;
			S_RPEVAL: state_d = sts.rd_free ? S_DROP : S_DONE;
			S_DROP:   state_d = S_DROPW;
			S_DROPW:  if (sts.drop_done) state_d = merged_q ? S_RPREV : S_DONE;
			S_DONE:   if (!sts.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.status = ST_OK;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				ctl.load    = in_valid;
				ctl.idx_clr = in_valid;
			end
			S_SCAN: begin
				ctl.rd = 1'b1;
				ctl.set_status = 1'b1;
				priority if (sts.cmd == CMD_ALLOC && sts.req_zero) ctl.status = ST_ZERO;
				else if (sts.cmd == CMD_RELEASE && sts.off_null) ctl.status = ST_NULL;
				else if (sts.idx_end)
					ctl.status = (sts.cmd == CMD_ALLOC) ? ST_NOFIT : ST_UNKNOWN;
				else ctl.set_status = 1'b0;
			end
			S_EVAL: begin
				if (sts.cmd == CMD_ALLOC) begin
					if (sts.fit) begin
						ctl.set_addr = 1'b1;
						if (sts.split_ok) ctl.alloc_split = 1'b1;
						else ctl.alloc_take = 1'b1;
					end else ctl.idx_inc = 1'b1;
				end else begin
					if (sts.match) begin
						if (sts.rd_free) begin
							ctl.set_status = 1'b1;
							ctl.status = ST_UNKNOWN;
						end else ctl.rel_mark = 1'b1;
					end else ctl.idx_inc = 1'b1;
				end
			end
			S_SPLIT:  ctl.ins_step = 1'b0;
			S_INS:    ctl.ins_step = 1'b1;
			S_RNEXT:  ctl.rd = 1'b1;
			S_RNEVAL: ctl.merge_next = !sts.idx_end && sts.rd_free;
			S_RPREV:  ctl.idx_dec = !sts.at_first;
			S_RPEVAL: ctl.merge_prev = sts.rd_free;
			S_DROP:   ctl.drop_start = 1'b1;
			S_DROPW:  ctl.drop_step = 1'b1;
			S_DONE:   ctl.out_load = !sts.out_busy;
			default:  ;
		endcase
	end

endmodule

FILE: rtl/ffba_dpath.sv
// ----------------------------------------------------------------------------
// ffba_dpath
// Block table memory, scan index, byte totals and result register.
// ----------------------------------------------------------------------------
module ffba_dpath #(
	parameter int unsigned HEAP_BYTES = 16777216,
	parameter int unsigned MAX_BLOCKS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          command,
	input  logic [ffba_pkg::REQ_W-1:0]    request_size,
	input  logic [ffba_pkg::OFF_W-1:0]    block_offset,
	input  ffba_pkg::ctl_t                ctl,
	output ffba_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [ffba_pkg::OFF_W-1:0]    address,
	output logic [ffba_pkg::OFF_W-1:0]    alloc_bytes,
	output logic [ffba_pkg::OFF_W-1:0]    avail_bytes
);
	import ffba_pkg::*;

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [OFF_W:0] INIT_FREE = (OFF_W+1)'(HEAP_BYTES - HDR_BYTES);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

	// entry: {free, size, start}
	localparam int unsigned EW = 2 * OFF_W + 1;
	logic [EW-1:0] mem [MAX_BLOCKS];
	logic [EW-1:0] rd_q;

	logic [CW-1:0]    count_q, idx_q, mv_q, stop_q;
	logic             mv_down_q;
	logic [OFF_W:0]   used_q, free_q;
	cmd_t             cmd_q;
	logic [REQ_W-1:0] req_q;
	logic [OFF_W-1:0] off_q;
	logic [OFF_W:0]   want_q;
	status_t          st_q;
	logic [OFF_W-1:0] addr_q;
	logic [EW-1:0]    hold_q;   // pending write data for insert / merge
	logic             init_q;   // entry 0 not yet written since reset

	logic             we;
	logic [IW-1:0]    wa, ra;
	logic [EW-1:0]    wd;
	logic [EW-1:0]    rdata;
	logic             rd_en;

	logic             rd_zero_q;
	logic [EW-1:0]    ent;
	logic [OFF_W-1:0] e_start, e_size;
	logic             e_free;
	assign rdata   = rd_q;
	assign ent     = rd_zero_q ? {1'b1, INIT_FREE[OFF_W-1:0], OFF_W'(0)} : rd_q;
	assign e_start = ent[OFF_W-1:0];
	assign e_size  = ent[2*OFF_W-1:OFF_W];
	assign e_free  = ent[EW-1];

	logic [OFF_W+1:0] want_plus;
	assign want_plus = {1'b0, want_q} + (OFF_W+2)'(2 * HDR_BYTES);

	// memory port control
	always_comb begin
		we = 1'b0;
		wa = idx_q[IW-1:0];
		wd = hold_q;
		rd_en = 1'b0;
		ra = idx_q[IW-1:0];
		if (ctl.rd) rd_en = 1'b1;
		if (ctl.idx_dec) begin
			ra = IW'(idx_q - CW'(2));
			rd_en = 1'b1;
		end
		if (ctl.alloc_take || ctl.alloc_split) begin
			we = 1'b1;
			wd = {1'b0, (ctl.alloc_split ? want_q[OFF_W-1:0] : e_size), e_start};
		end
		if (ctl.rel_mark) begin
			we = 1'b1;
			wd = {1'b1, e_size, e_start};
		end
		if (ctl.ins_step) begin
			// mv_q walks down from count to idx+1; read one below, write at mv
			we = (mv_q == stop_q) || mv_down_q;
			wa = mv_q[IW-1:0];
			wd = (mv_q == stop_q) ? hold_q : rdata;
			ra = mv_down_q ? IW'(mv_q - CW'(2)) : IW'(mv_q - CW'(1));
			rd_en = 1'b1;
		end
		if (ctl.drop_start) begin
			ra = IW'(mv_q + CW'(1));
			rd_en = 1'b1;
		end
		if (ctl.drop_step) begin
			we = mv_q + CW'(1) < count_q;
			wa = mv_q[IW-1:0];
			wd = rdata;
			ra = IW'(mv_q + CW'(2));
			rd_en = 1'b1;
		end
		if (ctl.merge_next || ctl.merge_prev) begin
			we = 1'b1;
			wa = IW'(idx_q - CW'(1));
			wd = {1'b1, hold_q[2*OFF_W-1:OFF_W] + e_size + OFF_W'(HDR_BYTES),
				(ctl.merge_prev ? e_start : hold_q[OFF_W-1:0])};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) rd_q <= mem[ra];
	end

	// entry 0 reads as reset value until first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b1;
			rd_zero_q <= 1'b0;
		end else begin
			if (we && wa == '0) init_q <= 1'b0;
			if (rd_en) rd_zero_q <= init_q && (ra == '0) && !(we && wa == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CW'(1);
			used_q    <= '0;
			free_q    <= INIT_FREE;
			idx_q     <= '0;
			mv_q      <= '0;
			stop_q    <= '0;
			mv_down_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (ctl.idx_clr) idx_q <= '0;
			else if (ctl.idx_inc || ctl.rel_mark) idx_q <= idx_q + CW'(1);
			else if (ctl.idx_dec) idx_q <= idx_q - CW'(1);
			if (ctl.alloc_take) begin
				used_q <= used_q + {1'b0, e_size};
				free_q <= free_q - {1'b0, e_size};
			end
			if (ctl.alloc_split) begin
				used_q    <= used_q + want_q;
				free_q    <= free_q - want_q - (OFF_W+1)'(HDR_BYTES);
				mv_q      <= count_q;
				stop_q    <= idx_q + CW'(1);
				mv_down_q <= 1'b0;
			end
			if (ctl.ins_step) begin
				mv_down_q <= 1'b1;
				if (mv_down_q) begin
					if (mv_q == stop_q) count_q <= count_q + CW'(1);
					else mv_q <= mv_q - CW'(1);
				end
			end
			if (ctl.rel_mark) begin
				used_q <= used_q - {1'b0, e_size};
				free_q <= free_q + {1'b0, e_size};
			end
			if (ctl.merge_next) begin
				free_q <= free_q + (OFF_W+1)'(HDR_BYTES);
				mv_q   <= idx_q;
			end
			if (ctl.merge_prev) begin
				free_q <= free_q + (OFF_W+1)'(HDR_BYTES);
				mv_q   <= idx_q;
			end
			if (ctl.drop_step) begin
				if (mv_q + CW'(1) < count_q) mv_q <= mv_q + CW'(1);
				else count_q <= count_q - CW'(1);
			end
		end
	end

	logic [REQ_W:0] round;
	assign round = ({1'b0, request_size} + (REQ_W+1)'(ALIGN_MASK)) & ~(REQ_W+1)'(ALIGN_MASK);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_t'(command);
			req_q  <= request_size;
			off_q  <= block_offset;
			want_q <= (round[REQ_W:OFF_W+1] != '0) ? '1 : round[OFF_W:0];
			st_q   <= ST_OK;
			addr_q <= '0;
		end
		if (ctl.set_status) st_q <= ctl.status;
		if (ctl.set_addr) addr_q <= e_start + OFF_W'(HDR_BYTES);
		if (ctl.alloc_split)
			hold_q <= {1'b1, OFF_W'({1'b0, e_size} - want_q - (OFF_W+1)'(HDR_BYTES)),
				OFF_W'({1'b0, e_start} + want_q + (OFF_W+1)'(HDR_BYTES))};
		if (ctl.rel_mark) hold_q <= {1'b1, e_size, e_start};
		if (ctl.merge_next || ctl.merge_prev)
			hold_q <= {1'b1, hold_q[2*OFF_W-1:OFF_W] + e_size + OFF_W'(HDR_BYTES),
				(ctl.merge_prev ? e_start : hold_q[OFF_W-1:0])};
		if (ctl.out_load) begin
			status      <= st_q;
			address     <= (st_q == ST_OK && cmd_q == CMD_ALLOC) ? addr_q : '0;
			alloc_bytes <= used_q[OFF_W-1:0];
			avail_bytes <= free_q[OFF_W-1:0];
		end
	end

	always_comb begin
		sts.cmd       = cmd_q;
		sts.req_zero  = (req_q == '0);
		sts.off_null  = (off_q == '0);
		sts.idx_end   = (idx_q >= count_q);
		sts.fit       = e_free && ({1'b0, e_size} >= want_q);
		sts.split_ok  = ({2'b0, e_size} >= want_plus) && (count_q < CNT_MAX);
		sts.match     = (e_start + OFF_W'(HDR_BYTES) == off_q);
		sts.rd_free   = e_free;
		sts.at_first  = (idx_q <= CW'(1));
		sts.ins_done  = mv_down_q && (mv_q == stop_q);
		sts.drop_done = !(mv_q + CW'(1) < count_q);
		sts.out_busy  = out_valid && out_stall;
	end

endmodule

FILE: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator over an address-ordered block table.
//
// Input channel in_valid/in_stall carries command, request_size and
// block_offset; one beat is taken when in_valid is high and in_stall low.
// An allocate rounds the size up to a multiple of 16 bytes and takes the
// first free block that fits, splitting off the rest when 32 or more bytes
// remain and the table has room. A release frees the block at the given
// payload offset and merges free neighbors. Each input beat yields one output
// beat (out_valid/out_stall) with status, address and the allocated and
// available byte totals. Entries are scanned in table order through a table
// memory with one write port and one read port. One item at a time: no new
// beat is taken until the output beat of the last item has been loaded.
// Reset gives one free block of HEAP_BYTES-16. A stalled output holds its
// beat; the next item is worked on and its beat waits until that one leaves.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int unsigned HEAP_BYTES = 16777216,
	parameter int unsigned MAX_BLOCKS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [ffba_pkg::REQ_W-1:0]  request_size,
	input  logic [ffba_pkg::OFF_W-1:0]  block_offset,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [ffba_pkg::OFF_W-1:0]  address,
	output logic [ffba_pkg::OFF_W-1:0]  alloc_bytes,
	output logic [ffba_pkg::OFF_W-1:0]  avail_bytes
);
	import ffba_pkg::*;

	ctl_t ctl;
	sts_t sts;

	ffba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .ctl(ctl)
	);

	ffba_dpath #(.HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .command(command),
		.request_size(request_size), .block_offset(block_offset),
		.ctl(ctl), .sts(sts), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .address(address), .alloc_bytes(alloc_bytes),
		.avail_bytes(avail_bytes)
	);

endmodule

FILE: bench/first_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit block allocator. A directed table
// covers the error codes, the size extremes and double release; random
// traffic then grows and shrinks the heap in alternating phases.
// Each output beat is checked against its directed value or an in-bench heap
// model, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffba_pkg::*;

	localparam int unsigned HEAP    = 16777216;
	localparam int unsigned NBLK    = 256;
	localparam int unsigned N_RAND  = 1400;
	localparam int unsigned TOP     = HEAP - HDR_BYTES;

	typedef struct {
		status_t     st;
		logic [23:0] addr;
		logic [23:0] used;
		logic [23:0] free;
	} beat_t;

	typedef struct {
		cmd_t        cmd;
		logic [24:0] req;
		logic [23:0] off;
		bit          typed;
		beat_t       want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [24:0] request_size = '0;
	logic [23:0] block_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [23:0] address, alloc_bytes, avail_bytes;

	// heap table model
	int unsigned blk_start[NBLK];
	int unsigned blk_size[NBLK];
	bit          blk_free[NBLK];
	int unsigned blk_cnt;
	int unsigned used_sum, free_sum;

	beat_t pending[$];
	int    mismatches = 0;
	int    unexpected = 0;
	int    n_results  = 0;
	bit    calm       = 1'b0;

	first_fit_block_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .request_size(request_size), .block_offset(block_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .address(address),
		.alloc_bytes(alloc_bytes), .avail_bytes(avail_bytes)
	);

	always #5 clk = ~clk;

	function automatic void heap_clear();
		blk_start[0] = 0;
		blk_size[0] = TOP;
		blk_free[0] = 1'b1;
		blk_cnt = 1;
		used_sum = 0;
		free_sum = TOP;
	endfunction

	function automatic void heap_drop(int unsigned idx);
		for (int unsigned k = idx; k + 1 < blk_cnt; k++) begin
			blk_start[k] = blk_start[k+1];
			blk_size[k] = blk_size[k+1];
			blk_free[k] = blk_free[k+1];
		end
		blk_cnt--;
	endfunction

	function automatic beat_t heap_step(cmd_t c, logic [24:0] req, logic [23:0] off);
		beat_t r;
		int unsigned want, have, i;
		r.addr = '0;
		r.st = ST_NOFIT;
		if (c == CMD_ALLOC) begin
			if (req == 0) begin
				r.st = ST_ZERO;
			end else begin
				want = (int'(req) + ALIGN_MASK) & ~ALIGN_MASK;
				for (i = 0; i < blk_cnt; i++) begin
					if (blk_free[i] && blk_size[i] >= want) begin
						have = blk_size[i];
						if (have >= want + HDR_BYTES + 16 && blk_cnt < NBLK) begin
							for (int unsigned k = blk_cnt; k > i + 1; k--) begin
								blk_start[k] = blk_start[k-1];
								blk_size[k] = blk_size[k-1];
								blk_free[k] = blk_free[k-1];
							end
							blk_start[i+1] = blk_start[i] + HDR_BYTES + want;
							blk_size[i+1] = have - want - HDR_BYTES;
							blk_free[i+1] = 1'b1;
							blk_cnt++;
							blk_size[i] = want;
							free_sum -= want + HDR_BYTES;
							used_sum += want;
						end else begin
							free_sum -= have;
							used_sum += have;
						end
						blk_free[i] = 1'b0;
						r.addr = 24'(blk_start[i] + HDR_BYTES);
						r.st = ST_OK;
						break;
					end
				end
			end
		end else if (off == 0) begin
			r.st = ST_NULL;
		end else begin
			for (i = 0; i < blk_cnt; i++)
				if (blk_start[i] + HDR_BYTES == off) break;
			if (i >= blk_cnt || blk_free[i]) begin
				r.st = ST_UNKNOWN;
			end else begin
				r.st = ST_OK;
				blk_free[i] = 1'b1;
				used_sum -= blk_size[i];
				free_sum += blk_size[i];
				if (i + 1 < blk_cnt && blk_free[i+1]) begin
					blk_size[i] += HDR_BYTES + blk_size[i+1];
					free_sum += HDR_BYTES;
					heap_drop(i + 1);
				end
				if (i > 0 && blk_free[i-1]) begin
					blk_size[i-1] += HDR_BYTES + blk_size[i];
					free_sum += HDR_BYTES;
					heap_drop(i);
				end
			end
		end
		r.used = 24'(used_sum);
		r.free = 24'(free_sum);
		return r;
	endfunction

	// one input beat; prediction is taken at acceptance
	task automatic offer(cmd_t c, logic [24:0] req, logic [23:0] off, bit typed, beat_t tw);
		beat_t p;
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			command <= 1'($urandom_range(1));
			request_size <= 25'($urandom);
			block_offset <= 24'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		request_size <= req;
		block_offset <= off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = heap_step(c, req, off);
		pending.push_back(typed ? tw : p);
	endtask

	function automatic beat_t mk(status_t s, int unsigned a, int unsigned u, int unsigned f);
		beat_t b;
		b.st = s; b.addr = 24'(a); b.used = 24'(u); b.free = 24'(f);
		return b;
	endfunction

	// output side: random stall, one long hold-off
	initial begin
		beat_t e;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				n_results++;
				if (pending.size() == 0) begin
					unexpected++;
					mismatches++;
					if (mismatches <= 10) $display("unexpected output beat at %0t", $realtime);
				end else begin
					e = pending.pop_front();
					if (status !== e.st || address !== e.addr ||
					    alloc_bytes !== e.used || avail_bytes !== e.free) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch beat %0d: exp st=%0d addr=%h used=%h free=%h,",
								" got st=%0d addr=%h used=%h free=%h"},
								n_results, e.st, e.addr, e.used, e.free,
								status, address, alloc_bytes, avail_bytes);
					end
				end
			end
			if (n_results == 300 && out_valid && !out_stall) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= (!calm && $urandom_range(99) < 30);
			end
		end
	end

	initial begin
		#60_000_000;
		$display("first_fit_block_allocator_tb: FAIL");
		$finish;
	end

	initial begin
		row_t        dir[$];
		row_t        rw;
		int unsigned roll, bias, idx;
		logic [24:0] sz;
		logic [23:0] o;
		int          guard;
		heap_clear();
		rw.typed = 1'b1;
		rw = '{CMD_ALLOC, 25'd0, 24'd0, 1'b1, mk(ST_ZERO, 0, 0, TOP)};              dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'h1FFFFFF, 24'd0, 1'b1, mk(ST_NULL, 0, 0, TOP)};      dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd16, 1'b1, mk(ST_UNKNOWN, 0, 0, TOP)};        dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'hFFFFFF, 1'b1, mk(ST_UNKNOWN, 0, 0, TOP)};    dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'h1FFFFFF, 24'd0, 1'b1, mk(ST_NOFIT, 0, 0, TOP)};       dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'(HEAP), 24'hFFFFFF, 1'b1, mk(ST_NOFIT, 0, 0, TOP)};    dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'(TOP), 24'd0, 1'b1, mk(ST_OK, 16, TOP, 0)};            dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'd1, 24'd0, 1'b1, mk(ST_NOFIT, 0, TOP, 0)};             dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd16, 1'b1, mk(ST_OK, 0, 0, TOP)};             dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd16, 1'b1, mk(ST_UNKNOWN, 0, 0, TOP)};        dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'd1, 24'd0, 1'b1, mk(ST_OK, 16, 16, TOP - 32)};         dir.push_back(rw);
		rw.typed = 1'b0;
		rw = '{CMD_ALLOC, 25'd33, 24'd0, 1'b0, rw.want};                            dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'd16, 24'd0, 1'b0, rw.want};                            dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'd100, 24'd0, 1'b0, rw.want};                           dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd64, 1'b0, rw.want};                          dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd24, 1'b0, rw.want};                          dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd16, 1'b0, rw.want};                          dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd112, 1'b0, rw.want};                         dir.push_back(rw);
		rw = '{CMD_ALLOC, 25'd48, 24'd0, 1'b0, rw.want};                            dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd144, 1'b0, rw.want};                         dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd16, 1'b0, rw.want};                          dir.push_back(rw);
		rw = '{CMD_RELEASE, 25'd0, 24'd160, 1'b0, rw.want};                         dir.push_back(rw);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) offer(dir[i].cmd, dir[i].req, dir[i].off, dir[i].typed, dir[i].want);

		for (int n = 0; n < N_RAND; n++) begin
			calm = (n >= 500 && n < 650);
			bias = ((n / 300) % 2 == 0) ? 78 : 45;
			roll = $urandom_range(99);
			if (roll < 8) begin
				offer(cmd_t'($urandom_range(1)), 25'($urandom), 24'($urandom), 1'b0, rw.want);
			end else if (roll < bias) begin
				case ($urandom_range(19))
					0: sz = 25'($urandom_range(1, 16777216));
					1: sz = 25'($urandom_range(256, 200000));
					2: sz = 25'd0;
					default: sz = 25'($urandom_range(1, 256));
				endcase
				offer(CMD_ALLOC, sz, 24'($urandom), 1'b0, rw.want);
			end else begin
				idx = $urandom_range(blk_cnt - 1);
				o = 24'(blk_start[idx] + HDR_BYTES);
				if ($urandom_range(15) == 0) o = o + 24'(8 * $urandom_range(1, 3));
				offer(CMD_RELEASE, 25'($urandom), o, 1'b0, rw.want);
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		guard = 0;
		while (pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (1200) @(posedge clk);
		if (pending.size() == 0 && mismatches == 0) begin
			$display("first_fit_block_allocator_tb: PASS");
		end else begin
			$display("first_fit_block_allocator_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: first_fit_block_allocator.f
rtl/ffba_pkg.sv
rtl/ffba_ctrl.sv
rtl/ffba_dpath.sv
rtl/first_fit_block_allocator.sv
bench/first_fit_block_allocator_tb.sv
